// File: hdl/tkpf_pkg.sv
// shared types, constants and codes for the top-k pair frequency tracker
`default_nettype none
package tkpf_pkg;
    localparam int TOP_ENTRIES = 32;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(TOP_ENTRIES);
    localparam int USED_W      = $clog2(TOP_ENTRIES + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_FEED  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ORDER    = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;
    localparam logic [1:0] ST_OPEN_RUN = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic        last_pair;
    } tkpf_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] estimate;
        logic        exact_match;
        logic [31:0] row_total;
        logic [31:0] distinct_total;
    } tkpf_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_SHIFT_RD,
        S_SHIFT_CMP,
        S_Q_RD,
        S_Q_CMP,
        S_DIV,
        S_OUT
    } tkpf_state_t;

    typedef struct packed {
        logic start;
        logic decode;
        logic ins_rd;
        logic ins_cmp;
        logic shift_rd;
        logic shift_cmp;
        logic q_rd;
        logic q_cmp;
        logic div_step;
        logic out_load;
    } tkpf_cmd_t;

    typedef struct packed {
        logic need_close;
        logic query_scan;
        logic scan_any;
        logic full;
        logic outr;
        logic pos_zero;
        logic pend2;
        logic q_hit;
        logic q_more;
        logic need_div;
        logic div_done;
        logic out_free;
    } tkpf_stat_t;
endpackage
`default_nettype wire

// File: hdl/tkpf_ctrl.sv
// controller state machine sequencing feed, insertion, query and division
`default_nettype none
module tkpf_ctrl import tkpf_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_go,
    input  wire tkpf_stat_t stat,
    output tkpf_cmd_t       cmd,
    output logic            busy
);
    tkpf_state_t state_reg, state_next;
    tkpf_state_t ins_done_next;

    assign ins_done_next = stat.pend2 ? S_INS_RD : S_OUT;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_go) state_next = S_DECODE;
            S_DECODE: begin
                if (stat.need_close) state_next = S_INS_RD;
                else if (stat.query_scan && stat.scan_any) state_next = S_Q_RD;
                else if (stat.query_scan && stat.need_div) state_next = S_DIV;
                else state_next = S_OUT;
            end
            S_INS_RD:    state_next = stat.full ? S_INS_CMP : S_SHIFT_RD;
            S_INS_CMP:   state_next = stat.outr ? S_SHIFT_RD : ins_done_next;
            S_SHIFT_RD:  state_next = stat.pos_zero ? ins_done_next : S_SHIFT_CMP;
            S_SHIFT_CMP: state_next = stat.outr ? S_SHIFT_RD : ins_done_next;
            S_Q_RD:      state_next = S_Q_CMP;
            S_Q_CMP: begin
                if (stat.q_hit) state_next = S_OUT;
                else if (stat.q_more) state_next = S_Q_RD;
                else if (stat.need_div) state_next = S_DIV;
                else state_next = S_OUT;
            end
            S_DIV:       if (stat.div_done) state_next = S_OUT;
            S_OUT:       if (stat.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.start = (state_reg == S_IDLE) && in_go;
        case (state_reg)
            S_DECODE:    cmd.decode = 1'b1;
            S_INS_RD:    cmd.ins_rd = 1'b1;
            S_INS_CMP:   cmd.ins_cmp = 1'b1;
            S_SHIFT_RD:  cmd.shift_rd = 1'b1;
            S_SHIFT_CMP: cmd.shift_cmp = 1'b1;
            S_Q_RD:      cmd.q_rd = 1'b1;
            S_Q_CMP:     cmd.q_cmp = 1'b1;
            S_DIV:       cmd.div_step = 1'b1;
            S_OUT:       cmd.out_load = stat.out_free;
            default:     cmd.out_load = 1'b0;
        endcase
        busy = (state_reg != S_IDLE);
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !stat.out_free) |=> (state_reg == S_OUT))
        else $error("result dropped before output register freed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && in_go) |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_RD && stat.full) |=> (state_reg == S_INS_CMP))
        else $error("insert compare skipped");
endmodule
`default_nettype wire

// File: hdl/tkpf_dp.sv
// datapath: statistics registers, top-k memory, run tracking and divider
`default_nettype none
module tkpf_dp import tkpf_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire tkpf_in_t  in_data,
    input  wire tkpf_cmd_t cmd,
    input  wire logic      out_ready,
    output tkpf_stat_t     stat,
    output logic           out_valid,
    output tkpf_out_t      out_data
);
    localparam logic [31:0] VMASK = (VALUE_BITS == 32) ? 32'hFFFF_FFFF
                                    : ((32'd1 << VALUE_BITS) - 32'd1);

    logic [63:0] keys_mem [TOP_ENTRIES];
    logic [31:0] cnts_mem [TOP_ENTRIES];

    logic [1:0]  in_cmd_reg;
    logic        in_last_reg;
    logic [63:0] key_reg;
    logic [USED_W-1:0] used_reg;
    logic [31:0] rows_reg, dist_reg, sum_reg, run_len_reg;
    logic [63:0] run_key_reg;
    logic        run_open_reg;
    logic        pend2_reg;
    logic [63:0] ins_key_reg;
    logic [31:0] ins_cnt_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [USED_W-1:0] scan_reg;
    logic [63:0] rd_key_reg;
    logic [31:0] rd_cnt_reg;
    logic [1:0]  status_reg;
    logic [31:0] est_reg;
    logic        exact_reg;
    logic [31:0] quo_reg, rem_reg;
    logic [5:0]  div_cnt_reg;
    tkpf_out_t   out_reg;
    logic        out_valid_reg;

    logic [IDX_W-1:0] rd_addr;
    logic        wr_en;
    logic [63:0] wr_key;
    logic [31:0] wr_cnt;
    logic [63:0] new_key;
    logic        outr, full, pos_zero, ins_fin;
    logic        is_feed, order_bad, sat, same_key, feed_ok, need_close;
    logic        query_scan, need_div;
    logic [31:0] rem_d, rem_r;
    logic [32:0] div_shift, div_trial;
    logic        div_ok;

    assign new_key = {in_data.first_value & VMASK, in_data.second_value & VMASK};

    assign outr = (ins_cnt_reg != rd_cnt_reg) ? (ins_cnt_reg > rd_cnt_reg)
                                                : (ins_key_reg < rd_key_reg);
    assign full = (used_reg == USED_W'(TOP_ENTRIES));
    assign pos_zero = (pos_reg == '0);
    assign ins_fin = (cmd.ins_cmp && !outr) || (cmd.shift_rd && pos_zero)
                     || (cmd.shift_cmp && !outr);

    assign is_feed   = (in_cmd_reg == CMD_FEED);
    assign order_bad = run_open_reg && (key_reg < run_key_reg);
    assign sat       = (rows_reg == 32'hFFFF_FFFF);
    assign feed_ok   = !order_bad && !sat;
    assign same_key  = run_open_reg && (key_reg == run_key_reg);
    assign need_close = is_feed && (feed_ok ? (same_key ? in_last_reg
                                                         : (run_open_reg || in_last_reg))
                                            : (in_last_reg && run_open_reg));

    assign rem_d = (dist_reg > 32'(used_reg)) ? dist_reg - 32'(used_reg) : 32'd0;
    assign rem_r = (rows_reg > sum_reg) ? rows_reg - sum_reg : 32'd0;
    assign need_div = (rem_d != 32'd0) && (rem_r != 32'd0);
    assign query_scan = (in_cmd_reg == CMD_QUERY) && !run_open_reg
                        && (rows_reg != 32'd0) && (dist_reg != 32'd0);

    // restoring division of the remaining rows by the remaining distinct pairs
    assign div_shift = {rem_reg, quo_reg[31]};
    assign div_ok    = div_shift >= {1'b0, rem_d};
    assign div_trial = div_shift - {1'b0, rem_d};

    always_comb begin
        rd_addr = pos_reg - IDX_W'(1);
        if (cmd.ins_rd) rd_addr = IDX_W'(TOP_ENTRIES - 1);
        else if (cmd.q_rd) rd_addr = scan_reg[IDX_W-1:0];
    end

    always_comb begin
        wr_en  = (cmd.shift_rd && pos_zero) || cmd.shift_cmp;
        wr_key = (cmd.shift_cmp && outr) ? rd_key_reg : ins_key_reg;
        wr_cnt = (cmd.shift_cmp && outr) ? rd_cnt_reg : ins_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        rd_key_reg <= keys_mem[rd_addr];
        rd_cnt_reg <= cnts_mem[rd_addr];
        if (wr_en) begin
            keys_mem[pos_reg] <= wr_key;
            cnts_mem[pos_reg] <= wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0; rows_reg <= '0; dist_reg <= '0; sum_reg <= '0;
            run_key_reg <= '0; run_len_reg <= '0; run_open_reg <= 1'b0;
            in_cmd_reg <= CMD_NONE; in_last_reg <= 1'b0; key_reg <= '0;
            pend2_reg <= 1'b0; pos_reg <= '0; scan_reg <= '0;
            status_reg <= ST_OK; est_reg <= '0; exact_reg <= 1'b0;
            quo_reg <= '0; rem_reg <= '0; div_cnt_reg <= '0;
            ins_key_reg <= '0; ins_cnt_reg <= '0;
            out_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                in_cmd_reg <= in_data.cmd;
                in_last_reg <= in_data.last_pair;
                key_reg <= new_key;
                status_reg <= ST_OK;
                est_reg <= '0;
                exact_reg <= 1'b0;
                scan_reg <= '0;
                pend2_reg <= 1'b0;
            end
            if (cmd.decode) begin
                quo_reg <= rem_r;
                rem_reg <= '0;
                div_cnt_reg <= '0;
                case (in_cmd_reg)
                    CMD_CLEAR: begin
                        used_reg <= '0; rows_reg <= '0; dist_reg <= '0; sum_reg <= '0;
                        run_key_reg <= '0; run_len_reg <= '0; run_open_reg <= 1'b0;
                    end
                    CMD_FEED: begin
                        if (!feed_ok) begin
                            status_reg <= order_bad ? ST_ORDER : ST_SAT;
                            if (in_last_reg && run_open_reg) begin
                                ins_key_reg <= run_key_reg; ins_cnt_reg <= run_len_reg;
                                run_open_reg <= 1'b0;
                            end
                        end else begin
                            rows_reg <= rows_reg + 32'd1;
                            if (same_key) begin
                                run_len_reg <= run_len_reg + 32'd1;
                                if (in_last_reg) begin
                                    ins_key_reg <= run_key_reg;
                                    ins_cnt_reg <= run_len_reg + 32'd1;
                                    run_open_reg <= 1'b0;
                                end
                            end else begin
                                run_key_reg <= key_reg;
                                run_len_reg <= 32'd1;
                                run_open_reg <= !in_last_reg;
                                if (run_open_reg) begin
                                    // prior run closes first, a last mark closes the new one
                                    ins_key_reg <= run_key_reg; ins_cnt_reg <= run_len_reg;
                                    pend2_reg <= in_last_reg;
                                end else begin
                                    ins_key_reg <= key_reg; ins_cnt_reg <= 32'd1;
                                end
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (run_open_reg) status_reg <= ST_OPEN_RUN;
                    end
                    default: status_reg <= ST_OK;
                endcase
            end
            if (cmd.ins_rd) begin
                if (dist_reg != 32'hFFFF_FFFF) dist_reg <= dist_reg + 32'd1;
                if (full) pos_reg <= IDX_W'(TOP_ENTRIES - 1);
                else begin
                    pos_reg <= used_reg[IDX_W-1:0];
                    used_reg <= used_reg + USED_W'(1);
                    sum_reg <= sum_reg + ins_cnt_reg;
                end
            end
            if (cmd.ins_cmp && outr) sum_reg <= sum_reg - rd_cnt_reg + ins_cnt_reg;
            if (cmd.shift_cmp && outr) pos_reg <= pos_reg - IDX_W'(1);
            if (ins_fin && pend2_reg) begin
                pend2_reg <= 1'b0;
                ins_key_reg <= key_reg;
                ins_cnt_reg <= 32'd1;
            end
            if (cmd.q_cmp) begin
                if (rd_key_reg == key_reg) begin
                    exact_reg <= 1'b1;
                    est_reg <= rd_cnt_reg;
                end
                scan_reg <= scan_reg + USED_W'(1);
            end
            if (cmd.div_step) begin
                if (div_cnt_reg == 6'd32) est_reg <= quo_reg + {31'd0, rem_reg != 32'd0};
                else begin
                    rem_reg <= div_ok ? div_trial[31:0] : div_shift[31:0];
                    quo_reg <= {quo_reg[30:0], div_ok};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
                out_reg <= '{status: status_reg, estimate: est_reg, exact_match: exact_reg,
                             row_total: rows_reg, distinct_total: dist_reg};
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.need_close = need_close;
        stat.query_scan = query_scan;
        stat.scan_any   = (used_reg != '0);
        stat.full       = full;
        stat.outr       = outr;
        stat.pos_zero   = pos_zero;
        stat.pend2      = pend2_reg;
        stat.q_hit      = (rd_key_reg == key_reg);
        stat.q_more     = (scan_reg + USED_W'(1)) < used_reg;
        stat.need_div   = need_div;
        stat.div_done   = (div_cnt_reg == 6'd32);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(TOP_ENTRIES)) else $error("list overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result changed before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        exact_reg |-> (status_reg == ST_OK)) else $error("exact with error status");
endmodule
`default_nettype wire

// File: hdl/top_k_pair_frequency_tracker.sv
// top level: tracks run frequencies of sorted pairs in a top-k list
// after accept a command is decoded; a feed that closes a run then inserts it into the list,
// a second run too if a last mark closes a new one; a query scans the list entries and may
// run the one-bit-a-cycle divider; one transaction is in flight at a time and s_ready
// returns as the result enters the output register and m_valid rises
// aresetn synchronous active low clears statistics; list memory is not cleared
`default_nettype none
module top_k_pair_frequency_tracker import tkpf_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tkpf_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output tkpf_out_t      m_data
);
    tkpf_cmd_t  cmd;
    tkpf_stat_t stat;
    logic       busy;

    assign s_ready = !busy;

    tkpf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_go(s_valid && s_ready),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    tkpf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_data(s_data), .cmd(cmd),
        .out_ready(m_ready), .stat(stat), .out_valid(m_valid), .out_data(m_data)
    );
endmodule
`default_nettype wire

// File: sim/top_k_pair_frequency_tracker_test.sv
// testbench for the top-k pair frequency tracker: random feeds and queries against a predictor
`default_nettype none
module top_k_pair_frequency_tracker_test import tkpf_pkg::*;;

    class pair_stats_board;
        logic [63:0] list_key [TOP_ENTRIES];
        logic [31:0] list_count [TOP_ENTRIES];
        int unsigned list_used;
        logic [31:0] rows, distinct, list_sum, run_len;
        logic [63:0] run_key;
        bit run_open;
        tkpf_out_t pending [$];
        int errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            list_used = 0;
            rows = 0;
            distinct = 0;
            list_sum = 0;
            run_len = 0;
            run_key = 0;
            run_open = 0;
        endfunction

        function bit ranks_above(logic [63:0] k, logic [31:0] f, int slot);
            if (f != list_count[slot]) return f > list_count[slot];
            return k < list_key[slot];
        endfunction

        function void offer(logic [63:0] k, logic [31:0] f);
            int p;
            logic [63:0] tk;
            logic [31:0] tc;
            if (list_used < TOP_ENTRIES) begin
                p = list_used;
                list_used++;
            end else begin
                p = TOP_ENTRIES - 1;
                if (!ranks_above(k, f, p)) return;
                list_sum -= list_count[p];
            end
            list_key[p] = k;
            list_count[p] = f;
            list_sum += f;
            while (p > 0 && ranks_above(list_key[p], list_count[p], p - 1)) begin
                tk = list_key[p-1];
                tc = list_count[p-1];
                list_key[p-1] = list_key[p];
                list_count[p-1] = list_count[p];
                list_key[p] = tk;
                list_count[p] = tc;
                p--;
            end
        endfunction

        function void close_run();
            if (distinct != 32'hffff_ffff) distinct++;
            offer(run_key, run_len);
            run_open = 0;
        endfunction

        function void note_input(tkpf_in_t t);
            tkpf_out_t r;
            logic [63:0] k;
            logic [32:0] rr, rd;
            k = {t.first_value, t.second_value};
            r = '0;
            if (t.cmd == CMD_CLEAR) begin
                wipe();
            end else if (t.cmd == CMD_FEED) begin
                if (run_open && k < run_key) r.status = ST_ORDER;
                else if (rows == 32'hffff_ffff) r.status = ST_SAT;
                else begin
                    rows++;
                    if (run_open && k == run_key) run_len++;
                    else begin
                        if (run_open) close_run();
                        run_key = k;
                        run_len = 1;
                        run_open = 1;
                    end
                end
                if (t.last_pair && run_open) close_run();
            end else if (t.cmd == CMD_QUERY) begin
                if (run_open) r.status = ST_OPEN_RUN;
                else if (rows != 0 && distinct != 0) begin
                    for (int i = 0; i < list_used; i++)
                        if (!r.exact_match && list_key[i] == k) begin
                            r.exact_match = 1;
                            r.estimate = list_count[i];
                        end
                    if (!r.exact_match) begin
                        rd = distinct > list_used ? distinct - list_used : 0;
                        rr = rows > list_sum ? rows - list_sum : 0;
                        if (rd != 0 && rr != 0) r.estimate = (rr + rd - 1) / rd;
                    end
                end
            end
            r.row_total = rows;
            r.distinct_total = distinct;
            pending.push_back(r);
        endfunction

        function void check_result(tkpf_out_t a);
            tkpf_out_t e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, a.status); errors++;
            end
            if (a.estimate !== e.estimate) begin
                $error("estimate expected %0d actual %0d", e.estimate, a.estimate); errors++;
            end
            if (a.exact_match !== e.exact_match) begin
                $error("exact_match expected %0d actual %0d", e.exact_match, a.exact_match);
                errors++;
            end
            if (a.row_total !== e.row_total) begin
                $error("row_total expected %0d actual %0d", e.row_total, a.row_total); errors++;
            end
            if (a.distinct_total !== e.distinct_total) begin
                $error("distinct_total expected %0d actual %0d", e.distinct_total,
                       a.distinct_total);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, m_ready = 0;
    tkpf_in_t s_data = '0;
    logic s_ready, m_valid;
    tkpf_out_t m_data;
    pair_stats_board board = new();
    bit feeding_done = 0;

    top_k_pair_frequency_tracker dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    task automatic send_item(logic [1:0] c, logic [31:0] a, logic [31:0] b, logic lp);
        int idle;
        idle = $urandom_range(0, 10);
        if (idle != 0) begin
            s_valid <= 0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{cmd: c, first_value: a, second_value: b, last_pair: lp};
        do @(posedge aclk); while (!s_ready);
        board.note_input('{cmd: c, first_value: a, second_value: b, last_pair: lp});
    endtask

    // sorted run of pairs with random repetition, closed by a last mark; some items are random pairs instead
    task automatic send_run_set(int n, bit wide);
        logic [31:0] a, b;
        a = wide ? $urandom() >> 4 : $urandom_range(0, 20);
        b = wide ? $urandom() : $urandom_range(0, 20);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 4)
                send_item(CMD_FEED, $urandom(), $urandom(), $urandom_range(0, 1));
            else
                send_item(CMD_FEED, a, b, i == n - 1);
            case ($urandom_range(0, 3))
                0: begin
                    a = a + 1;
                    b = wide ? $urandom() : $urandom_range(0, 20);
                end
                1: b = b + $urandom_range(1, 3);
                default: ;
            endcase
        end
    endtask

    task automatic send_queries(int n);
        for (int i = 0; i < n; i++)
            send_item(CMD_QUERY, $urandom_range(0, 3) ? $urandom_range(0, 25) : $urandom(),
                      $urandom_range(0, 25), $urandom_range(0, 1));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_FEED, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_FEED, 0, 0, 0);
        send_item(CMD_FEED, 0, 5, 0);
        send_item(CMD_FEED, 0, 1, 0);
        send_item(CMD_FEED, 32'hffff_ffff, 32'hffff_ffff, 1);
        send_item(CMD_QUERY, 32'hffff_ffff, 32'hffff_ffff, 1);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_QUERY, 7, 7, 0);
        send_item(CMD_FEED, 0, 0, 1);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 1);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_FEED, 5, 5, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_FEED, 32'haaaa_5555, 32'h5555_aaaa, 1);
        send_item(CMD_QUERY, 32'haaaa_5555, 32'h5555_aaaa, 0);
        for (int s = 0; s < 50; s++) begin
            if ($urandom_range(0, 5) == 0) send_item(CMD_CLEAR, $urandom(), $urandom(), 1);
            send_run_set($urandom_range(5, 50), $urandom_range(0, 3) == 0);
            send_queries($urandom_range(2, 8));
            if ($urandom_range(0, 9) == 0) send_item(CMD_NONE, $urandom(), $urandom(), 0);
        end
        s_valid <= 0;
        feeding_done = 1;
    end

    initial begin
        int hold;
        @(posedge aresetn);
        for (int n = 0; ; n++) begin
            hold = (n == 30) ? 300 : $urandom_range(0, 10);
            if (n % 50 > 40) hold = 0;
            if (hold != 0) begin
                m_ready <= 0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_data);
        end
    end

    initial begin
        wait (feeding_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: top_k_pair_frequency_tracker.f
hdl/tkpf_pkg.sv
hdl/tkpf_ctrl.sv
hdl/tkpf_dp.sv
hdl/top_k_pair_frequency_tracker.sv
sim/top_k_pair_frequency_tracker_test.sv
